// File: hdl/sadt_pkg.sv
// Shared types and register codes for the style attribute dedup table.
`timescale 1ns / 1ps
`default_nettype none
package sadt_pkg;

    // resolved appearance: colors carry the set flag in bit 24
    typedef struct packed {
        logic [24:0] fore;
        logic [24:0] back;
        logic [2:0]  flags;
    } t_appear;

    // register indexes on the configuration port
    localparam logic [1:0] REG_BASE_STYLE   = 2'd0;
    localparam logic [1:0] REG_MAX_STYLE    = 2'd1;
    localparam logic [1:0] REG_DEFAULT_FORE = 2'd2;
    localparam logic [1:0] REG_DEFAULT_BACK = 2'd3;

endpackage
`default_nettype wire

// File: hdl/sadt_table.sv
// Appearance store with one write port, one registered read port and the match compare.
`timescale 1ns / 1ps
`default_nettype none
module sadt_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire                                      i_clk,
    input  wire                                      i_wr_en,
    input  wire [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_wr_addr,
    input  wire sadt_pkg::t_appear                   i_wr_data,
    input  wire [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_rd_addr,
    input  wire sadt_pkg::t_appear                   i_probe,
    output logic                                     o_match
);

    sadt_pkg::t_appear r_mem [TABLE_DEPTH];
    sadt_pkg::t_appear r_rd_data;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    // compare the entry read last cycle against the probe
    assign o_match = (r_rd_data == i_probe);

endmodule
`default_nettype wire

// File: hdl/style_attribute_dedup_table.sv
// Top level: span appearance resolve, table scan sequencer, config port and result register.
`timescale 1ns / 1ps
`default_nettype none
// Each span with nonzero length is resolved (inverse fills unset colors from the
// defaults, then swaps), then the stored appearances are scanned one entry per
// cycle through the table's single read port, and the span is given the matching
// slot, a new slot, or slot 0 with the sticky budget flag; the scan stops at the
// first match. A result held by i_out_stall delays the finish of the following
// span. A zero-length span gives no result. o_in_stall is high while a span is
// being worked on. The result register lets the next span be accepted while a
// result still waits on i_out_stall. The table has no reset pass: entries are
// only read below the fill count, which reset and doc_start clear.
module style_attribute_dedup_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration port
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // span input
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire         i_doc_start,
    input  wire  [31:0] i_span_start,
    input  wire  [31:0] i_span_length,
    input  wire         i_fore_set,
    input  wire  [23:0] i_fore_rgb,
    input  wire         i_back_set,
    input  wire  [23:0] i_back_rgb,
    input  wire         i_bold,
    input  wire         i_italic,
    input  wire         i_underline,
    input  wire         i_inverse,
    input  wire         i_strike,
    // result output
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic [7:0]  o_style_number,
    output logic [31:0] o_out_start,
    output logic [31:0] o_out_length,
    output logic        o_strike_out,
    output logic        o_define_new,
    output logic        o_def_fore_set,
    output logic [23:0] o_def_fore_rgb,
    output logic        o_def_back_set,
    output logic [23:0] o_def_back_rgb,
    output logic [2:0]  o_def_flags,
    output logic        o_budget_exceeded,
    output logic [6:0]  o_styles_used
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    t_state             r_state;
    logic [7:0]         r_base;
    logic [7:0]         r_max;
    logic [24:0]        r_dflt_fore;
    logic [24:0]        r_dflt_back;
    logic [CNT_W-1:0]   r_count;
    logic               r_budget;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_slot;
    sadt_pkg::t_appear  r_probe;
    logic [31:0]        r_start;
    logic [31:0]        r_length;
    logic               r_strike;
    logic               r_out_valid;
    logic [7:0]         r_style;
    logic [31:0]        r_o_start;
    logic [31:0]        r_o_length;
    logic               r_o_strike;
    logic               r_o_define;
    sadt_pkg::t_appear  r_o_def;
    logic               r_o_budget;
    logic [CNT_W-1:0]   r_o_used;

    logic               in_accept;
    logic               cfg_wr;
    logic               out_free;
    logic               tbl_match;
    logic               tbl_wr;
    logic               room;
    logic [8:0]         cap;
    logic [24:0]        in_fore;
    logic [24:0]        in_back;
    sadt_pkg::t_appear  resolved;

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // register readback
    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            sadt_pkg::REG_BASE_STYLE:   prdata = {24'd0, r_base};
            sadt_pkg::REG_MAX_STYLE:    prdata = {24'd0, r_max};
            sadt_pkg::REG_DEFAULT_FORE: prdata = {7'd0, r_dflt_fore};
            sadt_pkg::REG_DEFAULT_BACK: prdata = {7'd0, r_dflt_back};
            default:                    prdata = '0;
        endcase
    end

    // appearance resolve: on inverse, fill unset colors from defaults, then swap
    always_comb begin
        in_fore = {i_fore_set, i_fore_rgb};
        in_back = {i_back_set, i_back_rgb};
        resolved.flags = {i_underline, i_italic, i_bold};
        if (i_inverse) begin
            resolved.fore = i_back_set ? in_back : r_dflt_back;
            resolved.back = i_fore_set ? in_fore : r_dflt_fore;
        end else begin
            resolved.fore = in_fore;
            resolved.back = in_back;
        end
    end

    // room check: capacity is max - base + 1, clamped to the table depth
    assign cap  = {1'b0, r_max} - {1'b0, r_base} + 9'd1;
    assign room = (r_max >= r_base) && (9'(r_count) < cap)
                  && (r_count < CNT_W'(TABLE_DEPTH));
    assign tbl_wr = (r_state == S_FIN) && out_free && !r_found && room;

    sadt_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (r_probe),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .i_probe   (r_probe),
        .o_match   (tbl_match)
    );

    // sequencer, configuration and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= 8'd0;
            r_max       <= 8'd255;
            r_dflt_fore <= '0;
            r_dflt_back <= '0;
            r_count     <= '0;
            r_budget    <= 1'b0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_o_budget  <= 1'b0;
            r_o_used    <= '0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    sadt_pkg::REG_BASE_STYLE:   r_base      <= pwdata[7:0];
                    sadt_pkg::REG_MAX_STYLE:    r_max       <= pwdata[7:0];
                    sadt_pkg::REG_DEFAULT_FORE: r_dflt_fore <= pwdata[24:0];
                    sadt_pkg::REG_DEFAULT_BACK: r_dflt_back <= pwdata[24:0];
                    default: ;
                endcase
            end

            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        if (i_doc_start) begin
                            r_count  <= '0;
                            r_budget <= 1'b0;
                        end
                        r_probe  <= resolved;
                        r_start  <= i_span_start;
                        r_length <= i_span_length;
                        r_strike <= i_strike;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        if (i_span_length != 32'd0) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // one read issued and one compare done each cycle
                    if (r_pend && tbl_match) begin
                        r_found <= 1'b1;
                        r_slot  <= r_pend_idx;
                        r_pend  <= 1'b0;
                        r_state <= S_FIN;
                    end else if (!r_pend && (r_idx >= r_count)) begin
                        r_found <= 1'b0;
                        r_state <= S_FIN;
                    end else begin
                        r_pend     <= (r_idx < r_count);
                        r_pend_idx <= r_idx[IDX_W-1:0];
                        if (r_idx < r_count) begin
                            r_idx <= r_idx + CNT_W'(1);
                        end
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_start   <= r_start;
                        r_o_length  <= r_length;
                        r_o_strike  <= r_strike;
                        r_o_define  <= 1'b0;
                        r_o_def     <= '0;
                        r_o_budget  <= r_budget;
                        r_o_used    <= r_count;
                        r_state     <= S_IDLE;
                        if (r_found) begin
                            r_style <= r_base + 8'(r_slot);
                        end else if (room) begin
                            r_style    <= r_base + 8'(r_count[IDX_W-1:0]);
                            r_count    <= r_count + CNT_W'(1);
                            r_o_used   <= r_count + CNT_W'(1);
                            r_o_define <= 1'b1;
                            r_o_def    <= r_probe;
                        end else begin
                            r_style    <= r_base;
                            r_budget   <= 1'b1;
                            r_o_budget <= 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_style_number    = r_style;
    assign o_out_start       = r_o_start;
    assign o_out_length      = r_o_length;
    assign o_strike_out      = r_o_strike;
    assign o_define_new      = r_o_define;
    assign o_def_fore_set    = r_o_def.fore[24];
    assign o_def_fore_rgb    = r_o_def.fore[23:0];
    assign o_def_back_set    = r_o_def.back[24];
    assign o_def_back_rgb    = r_o_def.back[23:0];
    assign o_def_flags       = r_o_def.flags;
    assign o_budget_exceeded = r_o_budget;
    assign o_styles_used     = 7'(r_o_used);

`ifndef ASSERT_OFF
    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // a span with nonzero length keeps the input stalled in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && (i_span_length != 32'd0)) |=> o_in_stall)
        else $error("input not stalled after span accepted");

    // a definition beat reports at least one entry held
    a_define_has_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_o_define) |-> (r_o_used != '0))
        else $error("definition with empty table");

    // budget flag only rises when a span finishes without room
    a_budget_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_budget) |-> ($past(r_state) == S_FIN))
        else $error("budget flag set outside finish step");
`endif

endmodule
`default_nettype wire

// File: tb/sv/style_attribute_dedup_table_tb.sv
// Testbench for the style attribute dedup table: find-or-insert predictor, random spans, stalls.
`timescale 1ns / 1ps
module style_attribute_dedup_table_tb;

    localparam int TABLE_DEPTH   = 64;
    // scan of a full table plus resolve and result stages, with margin
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;
    localparam int LONG_HOLD     = 300;
    localparam int LIMIT_CYCLES  = 500000;

    // one span beat as offered on the input channel
    typedef struct {
        logic        doc_start;
        logic [31:0] span_start;
        logic [31:0] span_length;
        logic        fore_set;
        logic [23:0] fore_rgb;
        logic        back_set;
        logic [23:0] back_rgb;
        logic        bold;
        logic        italic;
        logic        underline;
        logic        inverse;
        logic        strike;
    } span_t;

    // one style assignment beat as seen on the output channel
    typedef struct {
        logic [7:0]  style_number;
        logic [31:0] out_start;
        logic [31:0] out_length;
        logic        strike_out;
        logic        define_new;
        logic        def_fore_set;
        logic [23:0] def_fore_rgb;
        logic        def_back_set;
        logic [23:0] def_back_rgb;
        logic [2:0]  def_flags;
        logic        budget_exceeded;
        logic [6:0]  styles_used;
    } style_result_t;

    // Tracks the appearance table and queues the style assignment each span should get.
    class style_table_model;
        logic [7:0]        base_style;
        logic [7:0]        max_style;
        logic [24:0]       default_fore;
        logic [24:0]       default_back;
        sadt_pkg::t_appear appearances [TABLE_DEPTH];
        int                entries_held;
        bit                budget_hit;
        style_result_t     expected_styles [$];
        int                mismatches;
        int                results_checked;

        function new();
            base_style      = 8'd0;
            max_style       = 8'd255;
            default_fore    = 25'd0;
            default_back    = 25'd0;
            entries_held    = 0;
            budget_hit      = 1'b0;
            mismatches      = 0;
            results_checked = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                sadt_pkg::REG_BASE_STYLE:   base_style   = value[7:0];
                sadt_pkg::REG_MAX_STYLE:    max_style    = value[7:0];
                sadt_pkg::REG_DEFAULT_FORE: default_fore = value[24:0];
                sadt_pkg::REG_DEFAULT_BACK: default_back = value[24:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_styles.size();
        endfunction

        // resolve the span's appearance, then find it or claim a slot
        function void note_span(span_t s);
            sadt_pkg::t_appear look;
            logic [24:0]       fg;
            logic [24:0]       bg;
            int                cap;
            int                slot;
            int                k;
            bit                hit;
            bit                made;
            style_result_t     r;

            if (s.doc_start) begin
                entries_held = 0;
                budget_hit   = 1'b0;
            end
            if (s.span_length == 32'd0)
                return;

            fg = {s.fore_set, s.fore_rgb};
            bg = {s.back_set, s.back_rgb};
            // inverse: fill unset colors from defaults, then swap
            if (s.inverse) begin
                if (!fg[24]) fg = default_fore;
                if (!bg[24]) bg = default_back;
                {fg, bg} = {bg, fg};
            end
            look.fore  = fg;
            look.back  = bg;
            look.flags = {s.underline, s.italic, s.bold};

            slot = 0;
            hit  = 1'b0;
            made = 1'b0;
            for (k = 0; k < entries_held; k++) begin
                if (!hit && appearances[k] == look) begin
                    slot = k;
                    hit  = 1'b1;
                end
            end
            if (!hit) begin
                cap = int'(max_style) - int'(base_style) + 1;
                if (cap > TABLE_DEPTH) cap = TABLE_DEPTH;
                if (cap > 0 && entries_held < cap) begin
                    slot = entries_held;
                    appearances[slot] = look;
                    entries_held++;
                    made = 1'b1;
                end else begin
                    budget_hit = 1'b1;
                    slot       = 0;
                end
            end

            r = '{default: '0};
            r.style_number = base_style + 8'(slot);
            r.out_start    = s.span_start;
            r.out_length   = s.span_length;
            r.strike_out   = s.strike;
            r.define_new   = made;
            if (made) begin
                r.def_fore_set = look.fore[24];
                r.def_fore_rgb = look.fore[23:0];
                r.def_back_set = look.back[24];
                r.def_back_rgb = look.back[23:0];
                r.def_flags    = look.flags;
            end
            r.budget_exceeded = budget_hit;
            r.styles_used     = 7'(entries_held);
            expected_styles.insert(expected_styles.size(), r);
        endfunction

        task flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
            mismatches++;
            // keep the log bounded when the block is badly off
            if (mismatches <= 100)
                $display("[%0t] result %0d: %s got 0x%0h expected 0x%0h",
                         $time, results_checked, what, got, want);
        endtask

        task check_style(style_result_t got);
            style_result_t want;
            results_checked++;
            if (expected_styles.size() == 0) begin
                flag_mismatch("result with none expected", got.style_number, 32'd0);
                return;
            end
            want = expected_styles.pop_front();
            if (got.style_number !== want.style_number)
                flag_mismatch("style_number", got.style_number, want.style_number);
            if (got.out_start !== want.out_start)
                flag_mismatch("out_start", got.out_start, want.out_start);
            if (got.out_length !== want.out_length)
                flag_mismatch("out_length", got.out_length, want.out_length);
            if (got.strike_out !== want.strike_out)
                flag_mismatch("strike_out", got.strike_out, want.strike_out);
            if (got.define_new !== want.define_new)
                flag_mismatch("define_new", got.define_new, want.define_new);
            if (got.def_fore_set !== want.def_fore_set)
                flag_mismatch("def_fore_set", got.def_fore_set, want.def_fore_set);
            if (got.def_fore_rgb !== want.def_fore_rgb)
                flag_mismatch("def_fore_rgb", got.def_fore_rgb, want.def_fore_rgb);
            if (got.def_back_set !== want.def_back_set)
                flag_mismatch("def_back_set", got.def_back_set, want.def_back_set);
            if (got.def_back_rgb !== want.def_back_rgb)
                flag_mismatch("def_back_rgb", got.def_back_rgb, want.def_back_rgb);
            if (got.def_flags !== want.def_flags)
                flag_mismatch("def_flags", got.def_flags, want.def_flags);
            if (got.budget_exceeded !== want.budget_exceeded)
                flag_mismatch("budget_exceeded", got.budget_exceeded, want.budget_exceeded);
            if (got.styles_used !== want.styles_used)
                flag_mismatch("styles_used", got.styles_used, want.styles_used);
        endtask
    endclass

    // clock, reset and block ports
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [31:0] pwdata  = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_doc_start   = 1'b0;
    logic [31:0] i_span_start  = 32'd0;
    logic [31:0] i_span_length = 32'd0;
    logic        i_fore_set    = 1'b0;
    logic [23:0] i_fore_rgb    = 24'd0;
    logic        i_back_set    = 1'b0;
    logic [23:0] i_back_rgb    = 24'd0;
    logic        i_bold        = 1'b0;
    logic        i_italic      = 1'b0;
    logic        i_underline   = 1'b0;
    logic        i_inverse     = 1'b0;
    logic        i_strike      = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [7:0]  o_style_number;
    logic [31:0] o_out_start;
    logic [31:0] o_out_length;
    logic        o_strike_out;
    logic        o_define_new;
    logic        o_def_fore_set;
    logic [23:0] o_def_fore_rgb;
    logic        o_def_back_set;
    logic [23:0] o_def_back_rgb;
    logic [2:0]  o_def_flags;
    logic        o_budget_exceeded;
    logic [6:0]  o_styles_used;

    style_table_model sb;
    logic [24:0]      fore_pool [4];
    logic [24:0]      back_pool [4];
    bit               long_hold_done = 1'b0;

    style_attribute_dedup_table #(.TABLE_DEPTH(TABLE_DEPTH)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_doc_start(i_doc_start), .i_span_start(i_span_start),
        .i_span_length(i_span_length), .i_fore_set(i_fore_set), .i_fore_rgb(i_fore_rgb),
        .i_back_set(i_back_set), .i_back_rgb(i_back_rgb), .i_bold(i_bold),
        .i_italic(i_italic), .i_underline(i_underline), .i_inverse(i_inverse),
        .i_strike(i_strike),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_style_number(o_style_number), .o_out_start(o_out_start),
        .o_out_length(o_out_length), .o_strike_out(o_strike_out),
        .o_define_new(o_define_new), .o_def_fore_set(o_def_fore_set),
        .o_def_fore_rgb(o_def_fore_rgb), .o_def_back_set(o_def_back_set),
        .o_def_back_rgb(o_def_back_rgb), .o_def_flags(o_def_flags),
        .o_budget_exceeded(o_budget_exceeded), .o_styles_used(o_styles_used)
    );

    always #6 i_clk = ~i_clk;

    function automatic span_t make_span(logic doc, logic [31:0] st, logic [31:0] len,
                                        logic fs, logic [23:0] fr, logic bs,
                                        logic [23:0] br, logic [2:0] fl, logic inv,
                                        logic strk);
        span_t s;
        s.doc_start   = doc;
        s.span_start  = st;
        s.span_length = len;
        s.fore_set    = fs;
        s.fore_rgb    = fr;
        s.back_set    = bs;
        s.back_rgb    = br;
        s.bold        = fl[0];
        s.italic      = fl[1];
        s.underline   = fl[2];
        s.inverse     = inv;
        s.strike      = strk;
        return s;
    endfunction

    // mostly colors from a small pool so appearances repeat and the table fills
    function automatic span_t random_span(bit clear_now);
        span_t s;
        int    pick;
        pick          = $urandom_range(0, 99);
        s.doc_start   = clear_now || ($urandom_range(0, 99) < 3);
        s.span_start  = $urandom;
        s.span_length = (pick < 8) ? 32'd0 :
                        (pick < 40) ? $urandom_range(1, 200) : $urandom;
        if ($urandom_range(0, 99) < 70) begin
            {s.fore_set, s.fore_rgb} = fore_pool[$urandom_range(0, 3)];
            {s.back_set, s.back_rgb} = back_pool[$urandom_range(0, 3)];
        end else begin
            s.fore_set = 1'($urandom);
            s.fore_rgb = 24'($urandom);
            s.back_set = 1'($urandom);
            s.back_rgb = 24'($urandom);
        end
        s.bold      = 1'($urandom);
        s.italic    = 1'($urandom);
        s.underline = 1'($urandom);
        s.inverse   = ($urandom_range(0, 99) < 35);
        s.strike    = 1'($urandom);
        return s;
    endfunction

    function automatic void refresh_palette();
        int i;
        for (i = 0; i < 4; i++) begin
            fore_pool[i] = 25'($urandom);
            back_pool[i] = 25'($urandom);
        end
    endfunction

    // offer one span beat and hold it until accepted
    task automatic send_span(span_t s);
        i_in_valid    <= 1'b1;
        i_doc_start   <= s.doc_start;
        i_span_start  <= s.span_start;
        i_span_length <= s.span_length;
        i_fore_set    <= s.fore_set;
        i_fore_rgb    <= s.fore_rgb;
        i_back_set    <= s.back_set;
        i_back_rgb    <= s.back_rgb;
        i_bold        <= s.bold;
        i_italic      <= s.italic;
        i_underline   <= s.underline;
        i_inverse     <= s.inverse;
        i_strike      <= s.strike;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_span(s);
    endtask

    // config write: setup cycle, then access until pready
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
    endtask

    // stop offering, wait for every expected result, then let the block settle
    task automatic drain_block();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic configure(logic [7:0] base, logic [7:0] top, logic [24:0] dfore,
                             logic [24:0] dback);
        drain_block();
        write_reg(sadt_pkg::REG_BASE_STYLE, {24'd0, base});
        write_reg(sadt_pkg::REG_MAX_STYLE, {24'd0, top});
        write_reg(sadt_pkg::REG_DEFAULT_FORE, {7'd0, dfore});
        write_reg(sadt_pkg::REG_DEFAULT_BACK, {7'd0, dback});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // random spans in bursts with gaps; only spans with a result count
    task automatic run_random(int count, bit clear_first);
        int    produced;
        int    burst_left;
        int    gap;
        bit    first;
        span_t s;
        produced   = 0;
        first      = clear_first;
        burst_left = $urandom_range(1, 24);
        refresh_palette();
        while (produced < count) begin
            s = random_span(first);
            first = 1'b0;
            send_span(s);
            if (s.span_length != 32'd0) produced++;
            burst_left--;
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 90)
                                                  : $urandom_range(1, 12);
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed spans: extremes, inverse fills, color equality, clears
        configure(8'd0, 8'd255, 25'h1FFFFFF, 25'h0000000);
        send_span(make_span(1'b1, 32'd5, 32'd0, 1'b1, 24'h00FF00, 1'b0, 24'd0, 3'd0,
                            1'b0, 1'b0));
        send_span(make_span(1'b0, 32'd0, 32'd1, 1'b0, 24'd0, 1'b0, 24'd0, 3'd0,
                            1'b0, 1'b0));
        send_span(make_span(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 24'hFFFFFF, 1'b1,
                            24'hFFFFFF, 3'd7, 1'b0, 1'b1));
        send_span(make_span(1'b0, 32'd10, 32'd3, 1'b0, 24'd0, 1'b0, 24'd0, 3'd0,
                            1'b0, 1'b1));
        // unset color with nonzero RGB is a different appearance
        send_span(make_span(1'b0, 32'd20, 32'd4, 1'b0, 24'h123456, 1'b0, 24'd0, 3'd0,
                            1'b0, 1'b0));
        send_span(make_span(1'b0, 32'd30, 32'd2, 1'b0, 24'hABCDEF, 1'b0, 24'h654321,
                            3'd0, 1'b1, 1'b0));
        send_span(make_span(1'b0, 32'd40, 32'd2, 1'b1, 24'h112233, 1'b1, 24'h445566,
                            3'd0, 1'b1, 1'b0));
        send_span(make_span(1'b0, 32'd50, 32'd2, 1'b1, 24'h112233, 1'b0, 24'h445566,
                            3'd0, 1'b1, 1'b0));
        send_span(make_span(1'b0, 32'd60, 32'd2, 1'b0, 24'h112233, 1'b1, 24'h445566,
                            3'd0, 1'b1, 1'b0));
        send_span(make_span(1'b0, 32'd70, 32'd1, 1'b1, 24'h0000FF, 1'b1, 24'hFF0000,
                            3'b001, 1'b0, 1'b0));
        send_span(make_span(1'b0, 32'd71, 32'd1, 1'b1, 24'h0000FF, 1'b1, 24'hFF0000,
                            3'b010, 1'b0, 1'b0));
        send_span(make_span(1'b0, 32'd72, 32'd1, 1'b1, 24'h0000FF, 1'b1, 24'hFF0000,
                            3'b100, 1'b0, 1'b0));
        // zero length without a clear leaves the table alone
        send_span(make_span(1'b0, 32'hFFFFFFFF, 32'd0, 1'b1, 24'hFFFFFF, 1'b1,
                            24'hFFFFFF, 3'd7, 1'b1, 1'b1));
        send_span(make_span(1'b0, 32'd80, 32'd9, 1'b1, 24'hFFFFFF, 1'b1, 24'hFFFFFF,
                            3'd7, 1'b0, 1'b0));
        // inverse of a both-set span, so the swap alone sets the colors
        send_span(make_span(1'b0, 32'd90, 32'd1, 1'b1, 24'd0, 1'b1, 24'hFFFFFF, 3'd0,
                            1'b1, 1'b0));
        send_span(make_span(1'b1, 32'd100, 32'd7, 1'b1, 24'hFFFFFF, 1'b1, 24'hFFFFFF,
                            3'd7, 1'b0, 1'b1));

        // full capacity, then tight and empty budgets
        configure(8'd0, 8'd255, 25'($urandom), 25'($urandom));
        run_random(110, 1'b1);
        configure(8'd250, 8'd255, 25'h0000000, 25'h1FFFFFF);
        run_random(80, 1'b0);
        configure(8'd200, 8'd100, 25'($urandom), 25'($urandom));
        run_random(70, 1'b1);
        configure(8'd255, 8'd255, 25'h1FFFFFF, 25'h0FFFFFF);
        run_random(70, 1'b1);
        configure(8'd10, 8'd13, 25'($urandom), 25'($urandom));
        run_random(80, 1'b1);
        configure(8'd0, 8'd0, 25'h0FFFFFF, 25'h1000000);
        run_random(60, 1'b0);
        configure(8'd128, 8'd255, 25'($urandom), 25'($urandom));
        run_random(110, 1'b1);

        drain_block();
        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // output stall: random stretches of no, light or heavy stalling, plus one long hold
    initial begin : out_stall_gen
        int mode;
        int stretch;
        @(posedge i_clk);
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(10, 120);
            repeat (stretch) begin
                @(posedge i_clk);
                if (!long_hold_done && sb.results_checked >= 60) begin
                    // hold long enough that the block backs up into its input
                    long_hold_done = 1'b1;
                    i_out_stall <= 1'b1;
                    repeat (LONG_HOLD) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end else begin
                    case (mode)
                        0:       i_out_stall <= 1'b0;
                        1:       i_out_stall <= ($urandom_range(0, 99) < 25);
                        default: i_out_stall <= ($urandom_range(0, 99) < 75);
                    endcase
                end
            end
        end
    end

    // result monitor: every accepted beat is checked against the oldest expectation
    initial begin : result_monitor
        style_result_t got;
        @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                got.style_number    = o_style_number;
                got.out_start       = o_out_start;
                got.out_length      = o_out_length;
                got.strike_out      = o_strike_out;
                got.define_new      = o_define_new;
                got.def_fore_set    = o_def_fore_set;
                got.def_fore_rgb    = o_def_fore_rgb;
                got.def_back_set    = o_def_back_set;
                got.def_back_rgb    = o_def_back_rgb;
                got.def_flags       = o_def_flags;
                got.budget_exceeded = o_budget_exceeded;
                got.styles_used     = o_styles_used;
                sb.check_style(got);
            end
        end
    end

    // run limit
    initial begin : run_limit
        #(LIMIT_CYCLES * 12);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
